[rtl/fpa_pkg.sv]
// Package for the fixed-point ALU: command codes shared by the pipeline.
// No dependencies.
package fpa_pkg;

	// Operation selector carried on s_tuser
	typedef enum logic [3:0] {
		CMD_ADD      = 4'd0,
		CMD_SUB      = 4'd1,
		CMD_MUL      = 4'd2,
		CMD_DIV      = 4'd3,
		CMD_GT       = 4'd4,
		CMD_LT       = 4'd5,
		CMD_GE       = 4'd6,
		CMD_LE       = 4'd7,
		CMD_EQ       = 4'd8,
		CMD_NE       = 4'd9,
		CMD_MIN      = 4'd10,
		CMD_MAX      = 4'd11,
		CMD_INC      = 4'd12,
		CMD_DEC      = 4'd13,
		CMD_FROM_INT = 4'd14,
		CMD_TO_INT   = 4'd15
	} cmd_t;

	localparam int CMD_WIDTH = 4;

endpackage

[rtl/fixed_point_alu_unit.sv]
// Top level of the pipelined signed fixed-point ALU.
// Depends on fpa_pkg, fpa_div_step and fpa_out_skid.
//
// Channel  Direction  Carries
// s_*      in         tuser: cmd; tdata: operand_a, operand_b
// m_*      out        tdata: result_value; tuser: compare_true, overflow, divide_by_zero
//
// One transaction per cycle sustained while the skid entry is free. The pipeline is one decode
// stage, one restoring-divider stage per quotient bit and one output register.
// Every command walks the same pipeline so results leave in order.
// A skid entry after the last stage lets one more transaction enter while a result waits;
// the whole pipeline holds only while that entry is occupied.
// Reset clears all valid bits.
module fixed_point_alu_unit #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// [W-1:0] operand_a, [2W-1:W] operand_b, zero pad above
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]       s_tdata,
	// [3:0] cmd
	input  logic [fpa_pkg::CMD_WIDTH-1:0]           s_tuser,
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// [W-1:0] result_value, zero pad above
	output logic [((DATA_WIDTH+7)/8)*8-1:0]         m_tdata,
	// [0] compare_true, [1] overflow, [2] divide_by_zero
	output logic [2:0]                              m_tuser
);

	import fpa_pkg::*;

	localparam int W      = DATA_WIDTH;
	localparam int QW     = DATA_WIDTH + FRAC_BITS;
	localparam int OUT_W  = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int RES_W  = DATA_WIDTH + 3;

	localparam logic [W-1:0]   W_MAX    = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]   W_MIN    = {1'b1, {(W-1){1'b0}}};
	localparam logic [2*W:0]   MUL_HALF = ((2*W+1)'(1) << FRAC_BITS) >> 1;

	typedef struct packed {
		cmd_t           cmd;
		logic           neg;
		logic [W-1:0]   res;
		logic           cmp;
		logic           ovf;
		logic           dz;
		logic [2*W-1:0] prod;
	} side_t;

	typedef struct packed {
		logic [W-1:0] res;
		logic         dz;
		logic         ovf;
		logic         cmp;
	} result_t;

	logic          en;
	logic          valid_s [0:QW];
	side_t         side_s  [0:QW];
	logic [QW-1:0] num_s   [0:QW];
	logic [W-1:0]  rem_s   [0:QW];
	logic [QW-1:0] quo_s   [0:QW];
	logic [W-1:0]  den_s   [0:QW];

	// Decode inputs
	cmd_t          in_cmd;
	logic [W-1:0]  op_a;
	logic [W-1:0]  op_b;
	logic [W-1:0]  mag_a;
	logic [W-1:0]  mag_b;
	logic [W-1:0]  sum;
	logic [W-1:0]  diff;
	logic          a_lt_b;
	logic          a_eq_b;
	logic [FRAC_BITS:0] a_top;
	side_t         side_in;

	assign in_cmd = cmd_t'(s_tuser);
	assign op_a   = s_tdata[W-1:0];
	assign op_b   = s_tdata[2*W-1:W];
	assign a_top  = op_a[W-1 -: FRAC_BITS+1];

	// Compute the combinational operations and the magnitudes for multiply and divide
	always_comb begin
		mag_a  = op_a[W-1] ? (~op_a + 1'b1) : op_a;
		mag_b  = op_b[W-1] ? (~op_b + 1'b1) : op_b;
		sum    = op_a + op_b;
		diff   = op_a - op_b;
		a_lt_b = $signed(op_a) < $signed(op_b);
		a_eq_b = op_a == op_b;

		side_in      = '0;
		side_in.cmd  = in_cmd;
		side_in.neg  = op_a[W-1] ^ op_b[W-1];
		unique case (in_cmd)
			CMD_ADD: begin
				if (op_a[W-1] == op_b[W-1] && sum[W-1] != op_a[W-1]) begin
					side_in.ovf = 1'b1;
					side_in.res = op_a[W-1] ? W_MIN : W_MAX;
				end else begin
					side_in.res = sum;
				end
			end
			CMD_SUB: begin
				if (op_a[W-1] != op_b[W-1] && diff[W-1] != op_a[W-1]) begin
					side_in.ovf = 1'b1;
					side_in.res = op_a[W-1] ? W_MIN : W_MAX;
				end else begin
					side_in.res = diff;
				end
			end
			CMD_MUL: side_in.res = '0;
			CMD_DIV: side_in.dz  = (op_b == '0);
			CMD_GT:  side_in.cmp = !a_lt_b && !a_eq_b;
			CMD_LT:  side_in.cmp = a_lt_b;
			CMD_GE:  side_in.cmp = !a_lt_b;
			CMD_LE:  side_in.cmp = a_lt_b || a_eq_b;
			CMD_EQ:  side_in.cmp = a_eq_b;
			CMD_NE:  side_in.cmp = !a_eq_b;
			CMD_MIN: side_in.res = a_lt_b ? op_a : op_b;
			CMD_MAX: side_in.res = (!a_lt_b && !a_eq_b) ? op_a : op_b;
			CMD_INC: begin
				side_in.ovf = (op_a == W_MAX);
				side_in.res = (op_a == W_MAX) ? op_a : op_a + 1'b1;
			end
			CMD_DEC: begin
				side_in.ovf = (op_a == W_MIN);
				side_in.res = (op_a == W_MIN) ? op_a : op_a - 1'b1;
			end
			CMD_FROM_INT: begin
				if ((&a_top) || !(|a_top)) begin
					side_in.res = op_a << FRAC_BITS;
				end else begin
					side_in.ovf = 1'b1;
					side_in.res = op_a[W-1] ? W_MIN : W_MAX;
				end
			end
			CMD_TO_INT: side_in.res = W'($signed(op_a) >>> FRAC_BITS);
			default: side_in.res = '0;
		endcase
	end

	assign s_tready = en;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QW; i++) begin
				valid_s[i] <= 1'b0;
			end
		end else if (en) begin
			valid_s[0] <= s_tvalid;
			for (int i = 1; i <= QW; i++) begin
				valid_s[i] <= valid_s[i-1];
			end
		end
	end

	// Load the first stage
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			num_s[0]  <= {mag_a, {FRAC_BITS{1'b0}}};
			rem_s[0]  <= '0;
			quo_s[0]  <= '0;
			den_s[0]  <= mag_b;
		end
	end

	// Divider stages with the side data riding alongside
	for (genvar k = 0; k < QW; k++) begin : g_stage
		side_t          side_nxt;
		logic [2*W:0]   rnd;
		logic [2*W:0]   lim;

		fpa_div_step #(
			.DATA_WIDTH (W),
			.QUO_WIDTH  (QW)
		) u_step (
			.clk   (clk),
			.en    (en),
			.num_i (num_s[k]),
			.rem_i (rem_s[k]),
			.quo_i (quo_s[k]),
			.den_i (den_s[k]),
			.num_o (num_s[k+1]),
			.rem_o (rem_s[k+1]),
			.quo_o (quo_s[k+1]),
			.den_o (den_s[k+1])
		);

		// Multiply magnitudes in the first step, round and saturate in the second
		always_comb begin
			side_nxt = side_s[k];
			rnd      = ({1'b0, side_s[k].prod} + MUL_HALF) >> FRAC_BITS;
			lim      = {{(W+1){1'b0}}, side_s[k].neg ? W_MIN : W_MAX};
			if (k == 0) begin
				side_nxt.prod = num_s[k][QW-1:FRAC_BITS] * den_s[k];
			end else if (k == 1 && side_s[k].cmd == CMD_MUL) begin
				if (rnd > lim) begin
					side_nxt.ovf = 1'b1;
					side_nxt.res = side_s[k].neg ? W_MIN : W_MAX;
				end else begin
					side_nxt.res = side_s[k].neg ? (~rnd[W-1:0] + 1'b1) : rnd[W-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_nxt;
			end
		end
	end

	// Round and saturate the quotient, then pick the final result
	logic [QW:0] quo_rnd;
	logic [QW:0] quo_lim;
	result_t     fin;
	side_t       last;

	always_comb begin
		last    = side_s[QW];
		quo_rnd = {1'b0, quo_s[QW]} +
			(QW+1)'({rem_s[QW], 1'b0} >= {1'b0, den_s[QW]});
		quo_lim = {{(QW+1-W){1'b0}}, last.neg ? W_MIN : W_MAX};
		fin.res = last.res;
		fin.cmp = last.cmp;
		fin.ovf = last.ovf;
		fin.dz  = last.dz;
		if (last.cmd == CMD_DIV && !last.dz) begin
			if (quo_rnd > quo_lim) begin
				fin.ovf = 1'b1;
				fin.res = last.neg ? W_MIN : W_MAX;
			end else begin
				fin.res = last.neg ? (~quo_rnd[W-1:0] + 1'b1) : quo_rnd[W-1:0];
			end
		end
	end

	logic [RES_W-1:0] out_word;
	result_t          out_res;

	fpa_out_skid #(
		.WIDTH (RES_W)
	) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s[QW]),
		.in_data   (fin),
		.advance   (en),
		.out_valid (m_tvalid),
		.out_data  (out_word),
		.out_ready (m_tready)
	);

	// Unpack the result onto the master side
	assign out_res = result_t'(out_word);
	assign m_tdata = OUT_W'(out_res.res);
	assign m_tuser = {out_res.dz, out_res.ovf, out_res.cmp};

endmodule

[rtl/fpa_div_step.sv]
// One restoring-division stage: produces one quotient bit per cycle while en is high.
// No package dependency; instantiated once per quotient bit by the top level.
module fpa_div_step #(
	parameter int DATA_WIDTH = 32,
	parameter int QUO_WIDTH  = 40
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [QUO_WIDTH-1:0]  num_i,
	input  logic [DATA_WIDTH-1:0] rem_i,
	input  logic [QUO_WIDTH-1:0]  quo_i,
	input  logic [DATA_WIDTH-1:0] den_i,
	output logic [QUO_WIDTH-1:0]  num_o,
	output logic [DATA_WIDTH-1:0] rem_o,
	output logic [QUO_WIDTH-1:0]  quo_o,
	output logic [DATA_WIDTH-1:0] den_o
);

	logic [DATA_WIDTH:0]   rem_shift;
	logic [DATA_WIDTH:0]   rem_diff;
	logic                  fits;
	logic [DATA_WIDTH-1:0] rem_next;

	// Shift in the next dividend bit and trial-subtract the divisor
	always_comb begin
		rem_shift = {rem_i, num_i[QUO_WIDTH-1]};
		rem_diff  = rem_shift - {1'b0, den_i};
		fits      = rem_shift >= {1'b0, den_i};
		rem_next  = fits ? rem_diff[DATA_WIDTH-1:0] : rem_shift[DATA_WIDTH-1:0];
	end

	// Advance the partial result
	always_ff @(posedge clk) begin
		if (en) begin
			num_o <= {num_i[QUO_WIDTH-2:0], 1'b0};
			rem_o <= rem_next;
			quo_o <= {quo_i[QUO_WIDTH-2:0], fits};
			den_o <= den_i;
		end
	end

endmodule

[rtl/fpa_out_skid.sv]
// Output register with a skid entry, so the pipeline keeps moving while a result waits and the skid entry is free.
// No package dependency; used by the top level.
module fpa_out_skid #(
	parameter int WIDTH = 35
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [WIDTH-1:0] in_data,
	output logic             advance,
	output logic             out_valid,
	output logic [WIDTH-1:0] out_data,
	input  logic             out_ready
);

	logic             out_valid_q;
	logic [WIDTH-1:0] out_data_q;
	logic             skid_valid_q;
	logic [WIDTH-1:0] skid_data_q;
	logic             take;
	logic             drain;

	// Pipeline moves whenever the skid entry is free
	assign advance   = !skid_valid_q;
	assign take      = in_valid && advance;
	assign drain     = out_ready || !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			out_valid_q  <= skid_valid_q || take;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Move payload into the output register or park it in the skid entry
	always_ff @(posedge clk) begin
		if (drain) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (take) begin
			skid_data_q <= in_data;
		end
	end

endmodule
